// ===== rtl/core/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Default sizes and configuration register constants shared by the cache files.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  // Default number of entries and field widths.
  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_KEY_BITS   = 32;
  localparam int DEF_VALUE_BITS = 32;

  // Capacity register: width and value after reset.
  localparam int              CAP_BITS  = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

endpackage

// ===== rtl/core/lkvc_req_if.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache request channel
// Valid/ready channel that carries one get or put transaction.
// ----------------------------------------------------------------------------
interface lkvc_req_if #(
  parameter int KEY_BITS   = lkvc_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = lkvc_pkg::DEF_VALUE_BITS
);
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [KEY_BITS-1:0]   lookup_key;
  logic signed [VALUE_BITS-1:0] write_value;

  modport source (output valid, mode, lookup_key, write_value, input ready);
  modport sink   (input valid, mode, lookup_key, write_value, output ready);
endinterface

// ===== rtl/core/lkvc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache response channel
// Valid/ready channel that carries the result of one transaction.
// ----------------------------------------------------------------------------
interface lkvc_rsp_if #(
  parameter int KEY_BITS   = lkvc_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = lkvc_pkg::DEF_VALUE_BITS
);
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic signed [VALUE_BITS-1:0] read_value;
  logic                         evicted;
  logic signed [KEY_BITS-1:0]   evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

// ===== rtl/core/lkvc_ram.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache RAM
// Simple dual-port RAM, one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module lkvc_ram #(
  parameter int  WIDTH     = 32,
  parameter int  DEPTH     = 16,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/lru_key_value_cache_top.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each request transaction is a get (mode 0) or a put (mode 1) of one key and
// gives exactly one response transaction. The cache works on one request at a
// time. A request is accepted whenever the sequencer is idle, even while the
// previous response still waits in the output register. The metadata RAM has
// a single read port: one sweep over all entries finds the key, the least
// recent entry and the first free slot, and for a get hit and any put that
// stores a second read-modify-write sweep ages the ranks. The capacity
// register is written through cfg_we/cfg_wdata; the user must write it only
// while no transaction is in flight, which the block itself does not enforce.
// Values of zero act as one and values above ENTRIES act as ENTRIES. Valid
// bits and the fill count are cleared by reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top #(
  parameter int ENTRIES    = lkvc_pkg::DEF_ENTRIES,
  parameter int KEY_BITS   = lkvc_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = lkvc_pkg::DEF_VALUE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lkvc_pkg::CAP_BITS-1:0] cfg_wdata,
  lkvc_req_if.sink                      in_req,
  lkvc_rsp_if.source                    out_rsp
);

  import lkvc_pkg::*;

  // Index, counter and metadata widths. The metadata word holds the recency
  // rank above the key.
  localparam int IDX_BITS  = $clog2(ENTRIES);
  localparam int CNT_BITS  = $clog2(ENTRIES + 1);
  localparam int RANK_BITS = IDX_BITS;
  localparam int META_BITS = RANK_BITS + KEY_BITS;
  localparam int CMP_BITS  = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  // Control state.
  logic [2:0]          state_r, state_nxt;
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [CNT_BITS-1:0] fill_r, fill_nxt;
  logic [CAP_BITS-1:0] cap_r, cap_nxt;
  logic [CNT_BITS-1:0] iss_cnt_r, iss_cnt_nxt;
  logic                pend_r, pend_nxt;
  logic                val_pend_r, val_pend_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Request and search results.
  logic                  req_put_r, req_put_nxt;
  logic [KEY_BITS-1:0]   req_key_r, req_key_nxt;
  logic [VALUE_BITS-1:0] req_val_r, req_val_nxt;
  logic [IDX_BITS-1:0]   pend_idx_r, pend_idx_nxt;
  logic                  hit_r, hit_nxt;
  logic [IDX_BITS-1:0]   hit_slot_r, hit_slot_nxt;
  logic [RANK_BITS-1:0]  hit_rank_r, hit_rank_nxt;
  logic                  lru_found_r, lru_found_nxt;
  logic [IDX_BITS-1:0]   lru_slot_r, lru_slot_nxt;
  logic [RANK_BITS-1:0]  lru_rank_r, lru_rank_nxt;
  logic [KEY_BITS-1:0]   lru_key_r, lru_key_nxt;
  logic                  free_found_r, free_found_nxt;
  logic [IDX_BITS-1:0]   free_slot_r, free_slot_nxt;
  logic [IDX_BITS-1:0]   tgt_slot_r, tgt_slot_nxt;
  logic                  lim_all_r, lim_all_nxt;

  // Response being assembled, and the output register.
  logic                  res_hit_r, res_hit_nxt;
  logic [VALUE_BITS-1:0] res_rdval_r, res_rdval_nxt;
  logic                  res_ev_r, res_ev_nxt;
  logic [KEY_BITS-1:0]   res_evkey_r, res_evkey_nxt;
  logic                  out_hit_r, out_hit_nxt;
  logic [VALUE_BITS-1:0] out_rdval_r, out_rdval_nxt;
  logic                  out_ev_r, out_ev_nxt;
  logic [KEY_BITS-1:0]   out_evkey_r, out_evkey_nxt;

  // RAM ports.
  logic                  meta_wr_en, meta_rd_en;
  logic [IDX_BITS-1:0]   meta_wr_addr, meta_rd_addr;
  logic [META_BITS-1:0]  meta_wr_data, meta_rd_data;
  logic                  val_wr_en, val_rd_en;
  logic [IDX_BITS-1:0]   val_wr_addr, val_rd_addr;
  logic [VALUE_BITS-1:0] val_wr_data, val_rd_data;

  // Fields of the metadata word that arrives from the RAM.
  logic [RANK_BITS-1:0] rd_rank;
  logic [KEY_BITS-1:0]  rd_key;
  logic                 rd_valid;
  logic                 sweep_last;

  // Decision helpers.
  logic [CAP_BITS-1:0]  cap_sat;
  logic                 full;
  logic                 upd;
  logic [IDX_BITS-1:0]  slot_sel;

  assign rd_rank  = meta_rd_data[META_BITS-1:KEY_BITS];
  assign rd_key   = meta_rd_data[KEY_BITS-1:0];
  assign rd_valid = valid_r[pend_idx_r];

  // The last read of a sweep is being processed when every index has been
  // issued and one read is still in flight.
  assign sweep_last = (iss_cnt_r == CNT_BITS'(ENTRIES)) && pend_r;

  // Capacity saturation: zero acts as one, and the fill count can never pass
  // ENTRIES, so a capacity above it simply never triggers on its own.
  assign cap_sat = (cap_r == '0) ? CAP_BITS'(1) : cap_r;
  assign full    = (CMP_BITS'(fill_r) >= CMP_BITS'(cap_sat)) ||
                   (fill_r >= CNT_BITS'(ENTRIES));

  // Keys and recency ranks share one RAM; values live in a second one.
  lkvc_ram #(
    .WIDTH (META_BITS),
    .DEPTH (ENTRIES)
  ) u_meta_ram (
    .clk     (clk),
    .wr_en   (meta_wr_en),
    .wr_addr (meta_wr_addr),
    .wr_data (meta_wr_data),
    .rd_en   (meta_rd_en),
    .rd_addr (meta_rd_addr),
    .rd_data (meta_rd_data)
  );

  lkvc_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (ENTRIES)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (val_wr_en),
    .wr_addr (val_wr_addr),
    .wr_data (val_wr_data),
    .rd_en   (val_rd_en),
    .rd_addr (val_rd_addr),
    .rd_data (val_rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    fill_nxt       = fill_r;
    cap_nxt        = cfg_we ? cfg_wdata : cap_r;
    iss_cnt_nxt    = iss_cnt_r;
    pend_nxt       = 1'b0;
    val_pend_nxt   = val_pend_r;
    out_valid_nxt  = out_valid_r;
    req_put_nxt    = req_put_r;
    req_key_nxt    = req_key_r;
    req_val_nxt    = req_val_r;
    pend_idx_nxt   = pend_idx_r;
    hit_nxt        = hit_r;
    hit_slot_nxt   = hit_slot_r;
    hit_rank_nxt   = hit_rank_r;
    lru_found_nxt  = lru_found_r;
    lru_slot_nxt   = lru_slot_r;
    lru_rank_nxt   = lru_rank_r;
    lru_key_nxt    = lru_key_r;
    free_found_nxt = free_found_r;
    free_slot_nxt  = free_slot_r;
    tgt_slot_nxt   = tgt_slot_r;
    lim_all_nxt    = lim_all_r;
    res_hit_nxt    = res_hit_r;
    res_rdval_nxt  = res_rdval_r;
    res_ev_nxt     = res_ev_r;
    res_evkey_nxt  = res_evkey_r;
    out_hit_nxt    = out_hit_r;
    out_rdval_nxt  = out_rdval_r;
    out_ev_nxt     = out_ev_r;
    out_evkey_nxt  = out_evkey_r;

    meta_rd_en   = 1'b0;
    meta_rd_addr = iss_cnt_r[IDX_BITS-1:0];
    meta_wr_en   = 1'b0;
    meta_wr_addr = pend_idx_r;
    meta_wr_data = meta_rd_data;
    val_rd_en    = 1'b0;
    val_rd_addr  = hit_slot_r;
    val_wr_en    = 1'b0;
    val_wr_addr  = tgt_slot_r;
    val_wr_data  = req_val_r;
    upd          = 1'b0;
    slot_sel     = hit_slot_r;

    // The output register empties when the consumer takes the transaction.
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          req_put_nxt    = in_req.mode;
          req_key_nxt    = in_req.lookup_key;
          req_val_nxt    = in_req.write_value;
          iss_cnt_nxt    = '0;
          hit_nxt        = 1'b0;
          lru_found_nxt  = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt      = ST_SCAN;
        end
      end

      ST_SCAN, ST_UPDATE: begin
        // Issue one metadata read per cycle until every entry has been read.
        if (iss_cnt_r != CNT_BITS'(ENTRIES)) begin
          meta_rd_en   = 1'b1;
          iss_cnt_nxt  = iss_cnt_r + CNT_BITS'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = iss_cnt_r[IDX_BITS-1:0];
        end

        if (pend_r && (state_r == ST_SCAN)) begin
          // Search pass: first matching key, oldest valid entry, first hole.
          if (rd_valid && (rd_key == req_key_r) && !hit_r) begin
            hit_nxt      = 1'b1;
            hit_slot_nxt = pend_idx_r;
            hit_rank_nxt = rd_rank;
          end
          if (rd_valid && (!lru_found_r || (rd_rank > lru_rank_r))) begin
            lru_found_nxt = 1'b1;
            lru_slot_nxt  = pend_idx_r;
            lru_rank_nxt  = rd_rank;
            lru_key_nxt   = rd_key;
          end
          if (!rd_valid && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_slot_nxt  = pend_idx_r;
          end
        end else if (pend_r) begin
          // Aging pass: the target becomes most recent, and every other valid
          // entry younger than the limit moves one step older.
          if (pend_idx_r == tgt_slot_r) begin
            meta_wr_en   = 1'b1;
            meta_wr_data = {RANK_BITS'(0), req_key_r};
          end else if (rd_valid && (lim_all_r || (rd_rank < hit_rank_r))) begin
            meta_wr_en   = 1'b1;
            meta_wr_data = {rd_rank + RANK_BITS'(1), rd_key};
          end
        end

        // The value read issued by a get hit returns during the aging pass.
        if (val_pend_r) begin
          res_rdval_nxt = val_rd_data;
          val_pend_nxt  = 1'b0;
        end

        if (sweep_last) begin
          state_nxt = (state_r == ST_SCAN) ? ST_DECIDE : ST_DONE;
        end
      end

      ST_DECIDE: begin
        res_hit_nxt   = hit_r;
        res_rdval_nxt = '1;
        res_ev_nxt    = 1'b0;
        res_evkey_nxt = '0;
        lim_all_nxt   = 1'b1;

        if (hit_r) begin
          // Hit: refresh the entry; a put overwrites its value.
          upd         = 1'b1;
          slot_sel    = hit_slot_r;
          lim_all_nxt = 1'b0;
          if (req_put_r) begin
            val_wr_en = 1'b1;
          end else begin
            val_rd_en    = 1'b1;
            val_pend_nxt = 1'b1;
          end
        end else if (req_put_r && full) begin
          // New key with the cache full: reuse the least recent slot. The
          // valid bit and the fill count stay as they are.
          upd           = 1'b1;
          slot_sel      = lru_slot_r;
          val_wr_en     = 1'b1;
          res_ev_nxt    = 1'b1;
          res_evkey_nxt = lru_key_r;
        end else if (req_put_r && free_found_r) begin
          // New key with room left: fill the first free slot.
          upd                 = 1'b1;
          slot_sel            = free_slot_r;
          val_wr_en           = 1'b1;
          valid_nxt[slot_sel] = 1'b1;
          fill_nxt            = fill_r + CNT_BITS'(1);
        end

        val_wr_addr  = slot_sel;
        val_rd_addr  = slot_sel;
        tgt_slot_nxt = slot_sel;
        iss_cnt_nxt  = '0;
        state_nxt    = upd ? ST_UPDATE : ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_rdval_nxt = res_rdval_r;
          out_ev_nxt    = res_ev_r;
          out_evkey_nxt = res_evkey_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      fill_r      <= '0;
      cap_r       <= CAP_RESET;
      iss_cnt_r   <= '0;
      pend_r      <= 1'b0;
      val_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      fill_r      <= fill_nxt;
      cap_r       <= cap_nxt;
      iss_cnt_r   <= iss_cnt_nxt;
      pend_r      <= pend_nxt;
      val_pend_r  <= val_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    req_put_r    <= req_put_nxt;
    req_key_r    <= req_key_nxt;
    req_val_r    <= req_val_nxt;
    pend_idx_r   <= pend_idx_nxt;
    hit_r        <= hit_nxt;
    hit_slot_r   <= hit_slot_nxt;
    hit_rank_r   <= hit_rank_nxt;
    lru_found_r  <= lru_found_nxt;
    lru_slot_r   <= lru_slot_nxt;
    lru_rank_r   <= lru_rank_nxt;
    lru_key_r    <= lru_key_nxt;
    free_found_r <= free_found_nxt;
    free_slot_r  <= free_slot_nxt;
    tgt_slot_r   <= tgt_slot_nxt;
    lim_all_r    <= lim_all_nxt;
    res_hit_r    <= res_hit_nxt;
    res_rdval_r  <= res_rdval_nxt;
    res_ev_r     <= res_ev_nxt;
    res_evkey_r  <= res_evkey_nxt;
    out_hit_r    <= out_hit_nxt;
    out_rdval_r  <= out_rdval_nxt;
    out_ev_r     <= out_ev_nxt;
    out_evkey_r  <= out_evkey_nxt;
  end

  // A new request transaction is taken whenever the sequencer is idle.
  assign in_req.ready        = (state_r == ST_IDLE);
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.hit         = out_hit_r;
  assign out_rsp.read_value  = out_rdval_r;
  assign out_rsp.evicted     = out_ev_r;
  assign out_rsp.evicted_key = out_evkey_r;

endmodule
